// ===== rtl/tpe_pkg.sv =====
package tpe_pkg;

  // default pool size
  localparam int SLOTS_DEFAULT = 16;

  // field widths
  localparam int OP_W   = 2;
  localparam int TIME_W = 32;
  localparam int TAG_W  = 32;
  localparam int HDL_W  = 4;
  localparam int KIND_W = 3;
  localparam int SLOT_OUT_W = 4;

  // packed stream layouts
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  // operation codes
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SCHEDULED = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_EXPIRED   = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_TICK_DONE = 3'd4
  } kind_t;

  // per-slot status
  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_TIMED   = 2'd1,
    ST_PERSIST = 2'd2,
    ST_CANCEL  = 2'd3
  } slot_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic  clr_idx;
    logic  inc_idx;
    logic  sched_wr;
    logic  cancel_wr;
    logic  free_slot;
    logic  emit;
    kind_t emit_kind;
    logic  emit_slot;
    logic  emit_tag;
    logic  emit_last;
  } tpe_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic slot_timed;
    logic slot_cancel;
    logic expired;
    logic idx_last;
    logic out_free;
  } tpe_stat_t;

endpackage

// ===== rtl/timer_pool_expiry_engine.sv =====
// Timer pool expiry engine: a table of TIMER_SLOTS timer slots.
// Input stream s_*: one request per beat, s_tuser selects schedule, cancel
// or tick. Output stream m_*: result beats, m_tuser gives the result kind
// and m_tlast marks the final result of a request. Schedule and cancel give
// one result, a tick gives one expiry per due slot in ascending slot order
// and then a tick-done beat.
// Config channel cfg_*: one bit, 1 starts new timers at the last tick
// time, 0 at the request's current time; write it while idle.
// A schedule scans from slot 0 up to the lowest free slot, or reports full
// after the last one; a tick scans every slot, a timed slot also waiting
// for the registered entry read, and then loads the done beat.
// One request is in flight at a time; s_tready rises with the edge that
// loads the last result.
// A stalled m_tready holds the result register; the scan stops only where
// a result must be loaded, and walks on over the other slots.
// Reset frees every slot, clears the cached tick time and the config bit;
// entry memory is not cleared and needs no clearing pass.
module timer_pool_expiry_engine #(
  parameter int TIMER_SLOTS = tpe_pkg::SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // operation[1:0]
  input  logic [tpe_pkg::OP_W-1:0]          s_tuser,
  // current_time[31:0], delay[63:32], subject_tag[95:64], handle[99:96],
  // zero fill
  input  logic [tpe_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // kind[2:0]
  output logic [tpe_pkg::KIND_W-1:0]        m_tuser,
  // slot[3:0], tag_out[35:4], zero fill
  output logic [tpe_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_data
);

  tpe_pkg::tpe_cmd_t  cmd;
  tpe_pkg::tpe_stat_t stat;

  logic                               in_accept;
  logic [tpe_pkg::SLOT_OUT_W-1:0]     slot;
  logic [tpe_pkg::TAG_W-1:0]          tag_out;

  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // sequencer
  tpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot table and result register
  tpe_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_op     (s_tuser),
    .in_now    (s_tdata[31:0]),
    .in_delay  (s_tdata[63:32]),
    .in_tag    (s_tdata[95:64]),
    .in_handle (s_tdata[99:96]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_bit   (cfg_data[0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_slot  (slot),
    .out_tag   (tag_out),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, tag_out, slot};

endmodule

// ===== rtl/tpe_ctrl.sv =====
module tpe_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tpe_pkg::OP_W-1:0]      in_op,
  input  tpe_pkg::tpe_stat_t            stat,
  output tpe_pkg::tpe_cmd_t             cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_CANCEL,
    S_TICK_RD,
    S_TICK_CHK,
    S_TICK_END
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clr_idx = 1'b1;
          unique case (in_op)
            tpe_pkg::OP_SCHEDULE: state_next = S_SCHED;
            tpe_pkg::OP_CANCEL:   state_next = S_CANCEL;
            tpe_pkg::OP_TICK:     state_next = S_TICK_RD;
            default:              state_next = S_IDLE;
          endcase
        end
      end
      // walk slots until a free one turns up or the pool proves full
      S_SCHED: begin
        if (stat.slot_free) begin
          if (stat.out_free) begin
            cmd.sched_wr  = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_kind = tpe_pkg::KIND_SCHEDULED;
            cmd.emit_slot = 1'b1;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (stat.idx_last) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = tpe_pkg::KIND_FULL;
            cmd.emit_last = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      S_CANCEL: begin
        if (stat.out_free) begin
          cmd.cancel_wr = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = tpe_pkg::KIND_CANCELLED;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      // status look, timed slots go on to S_TICK_CHK for the registered memory read
      S_TICK_RD: begin
        if (stat.slot_timed) begin
          state_next = S_TICK_CHK;
        end else begin
          cmd.free_slot = stat.slot_cancel;
          if (stat.idx_last) begin
            state_next = S_TICK_END;
          end else begin
            cmd.inc_idx = 1'b1;
          end
        end
      end
      // due time compare and expiry report
      S_TICK_CHK: begin
        if (!stat.expired || stat.out_free) begin
          if (stat.expired) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = tpe_pkg::KIND_EXPIRED;
            cmd.emit_slot = 1'b1;
            cmd.emit_tag  = 1'b1;
            cmd.free_slot = 1'b1;
          end
          if (stat.idx_last) begin
            state_next = S_TICK_END;
          end else begin
            cmd.inc_idx = 1'b1;
            state_next  = S_TICK_RD;
          end
        end
      end
      S_TICK_END: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = tpe_pkg::KIND_TICK_DONE;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/tpe_dp.sv =====
module tpe_dp #(
  parameter int TIMER_SLOTS = tpe_pkg::SLOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_accept,
  input  logic [tpe_pkg::OP_W-1:0]          in_op,
  input  logic [tpe_pkg::TIME_W-1:0]        in_now,
  input  logic [tpe_pkg::TIME_W-1:0]        in_delay,
  input  logic [tpe_pkg::TAG_W-1:0]         in_tag,
  input  logic [tpe_pkg::HDL_W-1:0]         in_handle,
  input  logic                              cfg_we,
  input  logic                              cfg_bit,
  input  tpe_pkg::tpe_cmd_t                 cmd,
  output tpe_pkg::tpe_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tpe_pkg::KIND_W-1:0]        out_kind,
  output logic [tpe_pkg::SLOT_OUT_W-1:0]    out_slot,
  output logic [tpe_pkg::TAG_W-1:0]         out_tag,
  output logic                              out_last
);

  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int ENT_W  = tpe_pkg::TAG_W + 2 * tpe_pkg::TIME_W;

  // captured request
  logic [tpe_pkg::TIME_W-1:0] now_r;
  logic [tpe_pkg::TIME_W-1:0] delay_r;
  logic [tpe_pkg::TAG_W-1:0]  tag_r;
  logic [tpe_pkg::HDL_W-1:0]  handle_r;

  logic                       use_cached;
  logic [tpe_pkg::TIME_W-1:0] last_tick;

  logic [SLOT_W-1:0]          idx;
  tpe_pkg::slot_status_t      status [TIMER_SLOTS];

  logic [ENT_W-1:0]           mem [TIMER_SLOTS];
  logic [ENT_W-1:0]           rdata;

  logic [SLOT_W+3:0]          idx_wide;
  logic [SLOT_W+3:0]          hdl_wide;
  logic [SLOT_W-1:0]          hidx;
  logic                       hdl_ok;
  tpe_pkg::slot_status_t      cur_st;
  logic [tpe_pkg::TIME_W-1:0] start_sel;
  logic [tpe_pkg::TIME_W:0]   due;
  logic [tpe_pkg::TIME_W-1:0] rd_start;
  logic [tpe_pkg::TIME_W-1:0] rd_len;
  logic [tpe_pkg::TAG_W-1:0]  rd_tag;

  // request capture, cached tick time, config
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick  <= '0;
      use_cached <= 1'b0;
    end else begin
      if (in_accept && in_op == tpe_pkg::OP_TICK) begin
        last_tick <= in_now;
      end
      if (cfg_we) begin
        use_cached <= cfg_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_r    <= in_now;
      delay_r  <= in_delay;
      tag_r    <= in_tag;
      handle_r <= in_handle;
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  assign idx_wide = {4'b0, idx};
  assign hdl_wide = {SLOT_W'(0), handle_r};
  assign hidx     = hdl_wide[SLOT_W-1:0];
  assign hdl_ok   = (32'(handle_r) < TIMER_SLOTS);
  assign cur_st   = status[idx];

  // slot status flops
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TIMER_SLOTS; i++) begin
        status[i] <= tpe_pkg::ST_FREE;
      end
    end else begin
      if (cmd.sched_wr) begin
        status[idx] <= (delay_r != '0) ? tpe_pkg::ST_TIMED : tpe_pkg::ST_PERSIST;
      end
      if (cmd.free_slot) begin
        status[idx] <= tpe_pkg::ST_FREE;
      end
      if (cmd.cancel_wr && hdl_ok && status[hidx] != tpe_pkg::ST_FREE) begin
        status[hidx] <= tpe_pkg::ST_CANCEL;
      end
    end
  end

  // timer entry memory: tag, length, start
  assign start_sel = use_cached ? last_tick : now_r;

  always_ff @(posedge clk) begin
    if (cmd.sched_wr) begin
      mem[idx] <= {tag_r, delay_r, start_sel};
    end
    rdata <= mem[idx];
  end

  assign rd_start = rdata[tpe_pkg::TIME_W-1:0];
  assign rd_len   = rdata[2*tpe_pkg::TIME_W-1:tpe_pkg::TIME_W];
  assign rd_tag   = rdata[ENT_W-1:2*tpe_pkg::TIME_W];

  // due time at full width
  assign due = {1'b0, rd_start} + {1'b0, rd_len};

  always_comb begin
    stat             = '0;
    stat.slot_free   = (cur_st == tpe_pkg::ST_FREE);
    stat.slot_timed  = (cur_st == tpe_pkg::ST_TIMED);
    stat.slot_cancel = (cur_st == tpe_pkg::ST_CANCEL);
    stat.expired     = (due < {1'b0, now_r});
    stat.idx_last    = (idx == SLOT_W'(TIMER_SLOTS - 1));
    stat.out_free    = !out_valid || out_ready;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind <= cmd.emit_kind;
      out_slot <= cmd.emit_slot ? idx_wide[3:0] : '0;
      out_tag  <= cmd.emit_tag ? rd_tag : '0;
      out_last <= cmd.emit_last;
    end
  end

endmodule

// ===== tb/timer_pool_expiry_monitor.sv =====
module timer_pool_expiry_monitor #(
  parameter int TIMER_SLOTS = tpe_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // operation[1:0]
  input  logic [tpe_pkg::OP_W-1:0]       s_tuser,
  // current_time[31:0], delay[63:32], subject_tag[95:64], handle[99:96],
  // zero fill
  input  logic [tpe_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // kind[2:0]
  input  logic [tpe_pkg::KIND_W-1:0]     m_tuser,
  // slot[3:0], tag_out[35:4], zero fill
  input  logic [tpe_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [0:0]                     cfg_data,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tpe_pkg::kind_t                   kind;
    logic [tpe_pkg::SLOT_OUT_W-1:0]   slot;
    logic [tpe_pkg::TAG_W-1:0]        tag;
    logic                             last;
  } timer_result_t;

  // shadow copy of the timer table
  tpe_pkg::slot_status_t        slot_st    [TIMER_SLOTS];
  logic [tpe_pkg::TIME_W-1:0]   slot_start [TIMER_SLOTS];
  logic [tpe_pkg::TIME_W-1:0]   slot_delay [TIMER_SLOTS];
  logic [tpe_pkg::TAG_W-1:0]    slot_tag   [TIMER_SLOTS];
  logic [tpe_pkg::TIME_W-1:0]   tick_time;
  logic                         start_at_tick;

  timer_result_t       awaited_results [$];
  timer_result_t       want;
  int                  fail_cnt = 0;

  function automatic void await_result(tpe_pkg::kind_t k,
                                       logic [tpe_pkg::SLOT_OUT_W-1:0] s,
                                       logic [tpe_pkg::TAG_W-1:0] t, logic l);
    timer_result_t r;
    r.kind = k;
    r.slot = s;
    r.tag  = t;
    r.last = l;
    awaited_results.push_back(r);
  endfunction

  // work out the results one request causes and update the shadow table
  function automatic void predict_timer_request(logic [tpe_pkg::OP_W-1:0] op_in,
                                                logic [tpe_pkg::IN_DATA_W-1:0] word);
    logic [tpe_pkg::OP_W-1:0]   op;
    logic [tpe_pkg::TIME_W-1:0] now_us;
    logic [tpe_pkg::TIME_W-1:0] dly;
    logic [tpe_pkg::TAG_W-1:0]  tag;
    logic [tpe_pkg::HDL_W-1:0]  hdl;
    logic [tpe_pkg::TIME_W:0]   due;
    int                         free_idx;
    op       = op_in;
    now_us   = word[31:0];
    dly      = word[63:32];
    tag      = word[95:64];
    hdl      = word[99:96];
    free_idx = -1;
    case (op)
      tpe_pkg::OP_SCHEDULE: begin
        for (int i = 0; i < TIMER_SLOTS; i++)
          if (free_idx < 0 && slot_st[i] == tpe_pkg::ST_FREE) free_idx = i;
        if (free_idx < 0) begin
          await_result(tpe_pkg::KIND_FULL, '0, '0, 1'b1);
        end else begin
          slot_tag[free_idx]   = tag;
          slot_start[free_idx] = start_at_tick ? tick_time : now_us;
          slot_delay[free_idx] = dly;
          slot_st[free_idx]    = (dly != '0) ? tpe_pkg::ST_TIMED : tpe_pkg::ST_PERSIST;
          await_result(tpe_pkg::KIND_SCHEDULED, free_idx[tpe_pkg::SLOT_OUT_W-1:0],
                       '0, 1'b1);
        end
      end
      tpe_pkg::OP_CANCEL: begin
        if (int'(hdl) < TIMER_SLOTS && slot_st[hdl] != tpe_pkg::ST_FREE)
          slot_st[hdl] = tpe_pkg::ST_CANCEL;
        await_result(tpe_pkg::KIND_CANCELLED, '0, '0, 1'b1);
      end
      tpe_pkg::OP_TICK: begin
        tick_time = now_us;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (slot_st[i] == tpe_pkg::ST_CANCEL) begin
            slot_st[i] = tpe_pkg::ST_FREE;
          end else if (slot_st[i] == tpe_pkg::ST_TIMED) begin
            // 33-bit deadline, strictly past
            due = {1'b0, slot_start[i]} + {1'b0, slot_delay[i]};
            if (due < {1'b0, now_us}) begin
              await_result(tpe_pkg::KIND_EXPIRED, i[tpe_pkg::SLOT_OUT_W-1:0],
                           slot_tag[i], 1'b0);
              slot_st[i] = tpe_pkg::ST_FREE;
            end
          end
        end
        await_result(tpe_pkg::KIND_TICK_DONE, '0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // watch the three channels, compare results in order
  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_st[i]) slot_st[i] = tpe_pkg::ST_FREE;
      tick_time     = '0;
      start_at_tick = 1'b0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          fail_cnt++;
          $error("result with nothing awaited: kind %0d slot %0d tag_out %h",
                 m_tuser, m_tdata[3:0], m_tdata[35:4]);
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser !== want.kind) begin
            fail_cnt++;
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
          end
          if (m_tdata[3:0] !== want.slot) begin
            fail_cnt++;
            $error("slot: expected %0d, got %0d", want.slot, m_tdata[3:0]);
          end
          if (m_tdata[35:4] !== want.tag) begin
            fail_cnt++;
            $error("tag_out: expected %h, got %h", want.tag, m_tdata[35:4]);
          end
          if (m_tlast !== want.last) begin
            fail_cnt++;
            $error("last: expected %0d, got %0d", want.last, m_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) start_at_tick = cfg_data[0];
      if (s_tvalid && s_tready) predict_timer_request(s_tuser, s_tdata);
    end
    errors  <= fail_cnt;
    pending <= awaited_results.size();
  end

endmodule

// ===== tb/timer_pool_expiry_engine_test.sv =====
module timer_pool_expiry_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                       NUM_SLOTS  = 16;
  localparam logic [tpe_pkg::OP_W-1:0] OP_UNUSED  = 2'd3;
  localparam int                       IDLE_LIMIT = 5000;
  localparam int                       HOLD_LEN   = 300;
  localparam int                       DRAIN_WAIT = 40;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic [tpe_pkg::OP_W-1:0]       s_tuser   = '0;
  logic [tpe_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [tpe_pkg::KIND_W-1:0]     m_tuser;
  logic [tpe_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           m_tlast;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [0:0]                     cfg_data  = '0;

  int                         errors;
  int                         pending;
  int                         idle_cycles = 0;
  logic                       hold_trigger = 1'b0;
  logic                       hold_taken   = 1'b0;
  int                         hold_left    = 0;
  int                         stall_mode   = 0;
  int                         mode_left    = 0;
  int                         burst_left   = 8;
  logic [tpe_pkg::TIME_W-1:0] now_us       = '0;

  timer_pool_expiry_engine #(.TIMER_SLOTS(NUM_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  timer_pool_expiry_monitor #(.TIMER_SLOTS(NUM_SLOTS)) monitor (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: stall patterns, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_trigger && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_LEN;
      m_tready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 90);
      end
      mode_left--;
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (mode_left % 3 == 0);
      endcase
    end
  end

  // give up when nothing moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // random slot handle
  function automatic logic [tpe_pkg::HDL_W-1:0] rand_handle();
    logic [31:0] r;
    r = $urandom_range(0, 15);
    return r[tpe_pkg::HDL_W-1:0];
  endfunction

  // offer one request, then maybe open a gap before the next burst
  task automatic send_request(logic [tpe_pkg::OP_W-1:0] op,
                              logic [tpe_pkg::TIME_W-1:0] cur,
                              logic [tpe_pkg::TIME_W-1:0] dly,
                              logic [tpe_pkg::TAG_W-1:0] tag,
                              logic [tpe_pkg::HDL_W-1:0] hdl);
    int gap;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, hdl, tag, dly, cur};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 20);
    end
  endtask

  // stop offering and wait until every result is in and the scan is over
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_start_mode(logic mode);
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed traffic around a slowly advancing clock
  task automatic random_traffic(int count, int hold_at);
    int                         n;
    int                         pick;
    logic [tpe_pkg::TIME_W-1:0] dly;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      now_us += $urandom_range(0, 40);
      if ($urandom_range(0, 49) == 0) now_us = $urandom;
      if (n == hold_at) hold_trigger <= 1'b1;
      if (pick < 42) begin
        case ($urandom_range(0, 9))
          0: dly = '0;
          1: dly = $urandom;
          default: dly = $urandom_range(1, 150);
        endcase
        send_request(tpe_pkg::OP_SCHEDULE,
                     ($urandom_range(0, 9) == 0) ? $urandom : now_us, dly,
                     $urandom, rand_handle());
        n++;
      end else if (pick < 66) begin
        send_request(tpe_pkg::OP_CANCEL, $urandom, $urandom, $urandom, rand_handle());
        n++;
      end else if (pick < 95) begin
        send_request(tpe_pkg::OP_TICK, now_us, $urandom, $urandom, rand_handle());
        n++;
      end else begin
        // ignored code, does not count
        send_request(OP_UNUSED, $urandom, $urandom, $urandom, rand_handle());
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: start from the request time
    write_start_mode(1'b0);
    send_request(tpe_pkg::OP_SCHEDULE, 32'd5, '0, 32'hFFFF_FFFF, 4'd0);  // persistent
    send_request(tpe_pkg::OP_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0,
                 4'd15);                                                 // widest deadline
    send_request(tpe_pkg::OP_SCHEDULE, 32'd100, 32'd1, 32'hA5A5_A5A5, 4'd0);
    send_request(tpe_pkg::OP_TICK, 32'd101, '0, '0, 4'd0);               // deadline equals now
    send_request(tpe_pkg::OP_TICK, 32'd102, '0, '0, 4'd0);               // now past it
    send_request(tpe_pkg::OP_CANCEL, '0, '0, '0, 4'd15);                 // free slot
    send_request(tpe_pkg::OP_CANCEL, '0, '0, '0, 4'd0);                  // persistent one
    send_request(tpe_pkg::OP_CANCEL, '0, '0, '0, 4'd0);                  // already cancelled
    send_request(tpe_pkg::OP_TICK, 32'hFFFF_FFFF, '0, '0, 4'd0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    // fill the pool, overflow it, then expire every timer but the widest one
    repeat (NUM_SLOTS - 1) send_request(tpe_pkg::OP_SCHEDULE, '0, 32'd1, $urandom, 4'd0);
    send_request(tpe_pkg::OP_SCHEDULE, 32'd7, 32'd7, 32'd7, 4'd0);
    send_request(tpe_pkg::OP_TICK, 32'hFFFF_FFFF, '0, '0, 4'd0);
    drain();

    // random phases under both start-time modes
    now_us = 32'd1000;
    write_start_mode(1'b1);
    random_traffic(85, 30);
    drain();
    write_start_mode(1'b0);
    random_traffic(95, -1);
    drain();
    write_start_mode(1'b1);
    random_traffic(95, -1);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
